// ===== src/kvss_pkg.sv =====
// Package for the key/value stack search block: sizes, operation and status
// codes, controller states and the command/status bundles.
// No dependencies.
`default_nettype none

package kvss_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] status_t;

    localparam op_t OP_PUSH   = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_SEARCH = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_MISS  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_SCAN,
        S_REPLY
    } state_t;

    typedef enum logic [2:0] {
        RES_OK_ZERO,
        RES_FULL,
        RES_EMPTY,
        RES_MISS,
        RES_RDATA
    } res_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     push_wr;
        logic     pop_dec;
        logic     rd_en;
        logic     rd_from_cnt;
        logic     ptr_load;
        logic     ptr_dec;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic match;
        logic ptr_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/kvss_dp.sv =====
// Datapath of the key/value stack search block: pair memory, fill count,
// scan pointer, result and output registers. Depends on kvss_pkg.
`default_nettype none

module kvss_dp
    import kvss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    input  wire op_t                 in_op,
    input  wire logic [DATA_W-1:0]   in_key,
    input  wire logic [DATA_W-1:0]   in_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output status_t                  out_status,
    output logic [DATA_W-1:0]        out_key,
    output logic [DATA_W-1:0]        out_value,
    output logic [CNT_W-1:0]         out_count
);

    logic [DATA_W-1:0] key_mem   [DEPTH];
    logic [DATA_W-1:0] value_mem [DEPTH];

    op_t               op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rkey_reg;
    logic [DATA_W-1:0] rvalue_reg;
    status_t           res_status_reg;
    logic [DATA_W-1:0] res_key_reg;
    logic [DATA_W-1:0] res_value_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_key_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [CNT_W-1:0]  count_dec;

    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        rd_addr = cmd.rd_from_cnt ? count_dec[ADDR_W-1:0] : (ptr_reg - ADDR_W'(1));
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_wr)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop_dec)
            count_next = count_dec;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pair memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
        begin
            key_mem[count_reg[ADDR_W-1:0]]   <= key_reg;
            value_mem[count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            rkey_reg   <= key_mem[rd_addr];
            rvalue_reg <= value_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        if (cmd.ptr_load)
            ptr_reg <= count_dec[ADDR_W-1:0];
        else if (cmd.ptr_dec)
            ptr_reg <= ptr_reg - ADDR_W'(1);
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_FULL:
                begin
                    res_status_reg <= ST_FULL;
                    res_key_reg    <= '0;
                    res_value_reg  <= '0;
                end
                RES_EMPTY:
                begin
                    res_status_reg <= ST_EMPTY;
                    res_key_reg    <= '0;
                    res_value_reg  <= '0;
                end
                RES_MISS:
                begin
                    res_status_reg <= ST_MISS;
                    res_key_reg    <= '1;
                    res_value_reg  <= '1;
                end
                RES_RDATA:
                begin
                    res_status_reg <= ST_OK;
                    res_key_reg    <= rkey_reg;
                    res_value_reg  <= rvalue_reg;
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                    res_key_reg    <= '0;
                    res_value_reg  <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(DEPTH));
    assign stat.match    = (rkey_reg == key_reg);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

// ===== src/kvss_ctrl.sv =====
// Controller of the key/value stack search block: sequences push, pop and
// the newest-first key scan. Depends on kvss_pkg.
`default_nettype none

module kvss_ctrl
    import kvss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_REPLY;
                case (stat.op)
                    OP_PUSH:
                    begin
                        if (stat.full)
                            cmd.res_sel = RES_FULL;
                        else
                        begin
                            cmd.res_sel = RES_OK_ZERO;
                            cmd.push_wr = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (stat.empty)
                            cmd.res_sel = RES_EMPTY;
                        else
                        begin
                            // Read the top slot; result waits for the data.
                            cmd.res_load    = 1'b0;
                            cmd.pop_dec     = 1'b1;
                            cmd.rd_en       = 1'b1;
                            cmd.rd_from_cnt = 1'b1;
                            state_next      = S_POP_RD;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (stat.empty)
                            cmd.res_sel = RES_MISS;
                        else
                        begin
                            cmd.res_load    = 1'b0;
                            cmd.rd_en       = 1'b1;
                            cmd.rd_from_cnt = 1'b1;
                            cmd.ptr_load    = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                        cmd.res_sel = RES_OK_ZERO;
                endcase
            end
            S_POP_RD:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RDATA;
                state_next   = S_REPLY;
            end
            S_SCAN:
            begin
                // Compare the slot read last cycle; on a miss with older slots left, fetch the next older one.
                if (stat.match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RDATA;
                    state_next   = S_REPLY;
                end
                else if (stat.ptr_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = S_REPLY;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_dec = 1'b1;
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/key_value_stack_search_top.sv =====
// Key/value stack search: bounded LIFO of key/value pairs, newest-first key search.
// Push and op code 3 reply from the latched beat; pop reads the top slot first; a search steps
// past the older slots (at most DEPTH - 1), one per cycle on the registered read port.
// One item in flight: a new beat is taken only once the last result is loaded for output;
// a waiting result holds the next item at its reply.
// Reset (rst_n, asynchronous, active low) empties the stack and the output register.
`default_nettype none

module key_value_stack_search_top
    import kvss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave side: one operation per beat.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    // Master side: one result per beat.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] out_key, [63:32] out_value,
                                        // [70:64] count, [71] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    cmd_t              cmd;
    stat_t             stat;
    status_t           out_status;
    logic [DATA_W-1:0] out_key;
    logic [DATA_W-1:0] out_value;
    logic [CNT_W-1:0]  out_count;

    // Sequencer: handshake on the slave side, commands to the datapath.
    kvss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, scan compare and the output register.
    kvss_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_key     (s_tdata[31:0]),
        .in_value   (s_tdata[63:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_key    (out_key),
        .out_value  (out_value),
        .out_count  (out_count)
    );

    // Pack the result beat; pad to whole bytes with zeros.
    assign m_tdata = {{(72 - 2*DATA_W - CNT_W){1'b0}}, out_count, out_value, out_key};
    assign m_tuser = out_status;

endmodule

`default_nettype wire
